FILE: rtl/core/bc_pkg.sv
// Shared types and constants for the binomial coefficient unit.
`timescale 1ns / 1ps

package bc_pkg;

   // Widths of the transaction fields
   localparam int ARG_W     = 7;
   localparam int COEF_BITS = 64;

   // Defaults for the top-level parameters
   localparam int ARG_BITS_DEF    = 7;
   localparam int RESULT_BITS_DEF = 64;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_K_GT_N   = 2'd1,
      ST_OVERFLOW = 2'd2
   } bc_status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_MUL,
      S_DIV,
      S_CHECK,
      S_DONE
   } bc_state_type;

   // Datapath operations issued by the sequencer
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_MUL,
      OP_DIV,
      OP_CHECK
   } bc_op_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic k_gt_n;
      logic k_eff_zero;
      logic div_last;
      logic quo_over;
      logic i_last;
   } bc_flags_type;

endpackage

FILE: rtl/core/bc_channels.sv
// Valid/ready channel interfaces for request and response transactions.
`timescale 1ns / 1ps

interface bc_req_if import bc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ARG_W-1:0] n_total;
   logic [ARG_W-1:0] k_chosen;

   modport source (output valid, output n_total, output k_chosen, input ready);
   modport sink   (input valid, input n_total, input k_chosen, output ready);
endinterface

interface bc_rsp_if import bc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COEF_BITS-1:0] coefficient;
   bc_status_type        status;

   modport source (output valid, output coefficient, output status, input ready);
   modport sink   (input valid, input coefficient, input status, output ready);
endinterface

FILE: rtl/core/bc_datapath.sv
// Datapath: accumulator, product register and shared radix-2 divider.
`timescale 1ns / 1ps

module bc_datapath import bc_pkg::*; #(
   parameter int ARG_BITS    = ARG_BITS_DEF,
   parameter int RESULT_BITS = RESULT_BITS_DEF
) (
   input  logic                 clock,
   input  bc_op_type            op,
   input  logic [ARG_BITS-1:0]  n_in,
   input  logic [ARG_BITS-1:0]  k_in,
   output bc_flags_type         flags,
   output logic [COEF_BITS-1:0] res_coef,
   output bc_status_type        res_status
);

   localparam int PROD_BITS = RESULT_BITS + ARG_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS);

   logic [ARG_BITS-1:0]    n_ff, k_ff, i_ff, rem_ff;
   logic [RESULT_BITS-1:0] acc_ff;
   logic [PROD_BITS-1:0]   dvd_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [COEF_BITS-1:0]   coef_ff;
   bc_status_type          status_ff;

   logic [ARG_BITS-1:0]    k_eff, m_val, rem_next;
   logic [PROD_BITS-1:0]   prod;
   logic [ARG_BITS:0]      rem_sh, diff;
   logic                   fits;
   logic [RESULT_BITS-1:0] res_max;

   // Reflect k to n-k when k exceeds n/2
   assign k_eff = (k_ff > (n_ff >> 1)) ? (n_ff - k_ff) : k_ff;

   // Multiplier term n-k+i, never above n
   assign m_val = n_ff - k_ff + i_ff;
   assign prod  = PROD_BITS'(acc_ff) * PROD_BITS'(m_val);

   // One restoring division step, quotient bits shift into the dividend
   assign rem_sh   = {rem_ff, dvd_ff[PROD_BITS-1]};
   assign diff     = rem_sh - {1'b0, i_ff};
   assign fits     = ~diff[ARG_BITS];
   assign rem_next = fits ? diff[ARG_BITS-1:0] : rem_sh[ARG_BITS-1:0];

   assign res_max = {RESULT_BITS{1'b1}};

   // Flags for the sequencer
   always_comb begin
      flags.k_gt_n     = k_ff > n_ff;
      flags.k_eff_zero = k_eff == '0;
      flags.div_last   = cnt_ff == CNT_BITS'(PROD_BITS - 1);
      flags.quo_over   = |dvd_ff[PROD_BITS-1:RESULT_BITS];
      flags.i_last     = i_ff == k_ff;
   end

   // Datapath registers, driven by the current operation
   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            n_ff <= n_in;
            k_ff <= k_in;
         end
         OP_SETUP: begin
            k_ff   <= k_eff;
            i_ff   <= ARG_BITS'(1);
            acc_ff <= RESULT_BITS'(1);
            if (k_ff > n_ff) begin
               coef_ff   <= '0;
               status_ff <= ST_K_GT_N;
            end else begin
               coef_ff   <= COEF_BITS'(1);
               status_ff <= ST_OK;
            end
         end
         OP_MUL: begin
            dvd_ff <= prod;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         OP_DIV: begin
            dvd_ff <= {dvd_ff[PROD_BITS-2:0], fits};
            rem_ff <= rem_next;
            cnt_ff <= cnt_ff + CNT_BITS'(1);
         end
         OP_CHECK: begin
            if (|dvd_ff[PROD_BITS-1:RESULT_BITS]) begin
               coef_ff   <= COEF_BITS'(res_max);
               status_ff <= ST_OVERFLOW;
            end else begin
               acc_ff    <= dvd_ff[RESULT_BITS-1:0];
               coef_ff   <= COEF_BITS'(dvd_ff[RESULT_BITS-1:0]);
               status_ff <= ST_OK;
            end
            i_ff <= i_ff + ARG_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   assign res_coef   = coef_ff;
   assign res_status = status_ff;

endmodule

FILE: rtl/core/bc_ctrl.sv
// Sequencer: steps the datapath through multiply and divide rounds.
`timescale 1ns / 1ps

module bc_ctrl import bc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         rsp_free,
   input  bc_flags_type flags,
   output logic         req_ready,
   output logic         rsp_load,
   output bc_op_type    op
);

   bc_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SETUP;
         end
         S_SETUP: begin
            if (flags.k_gt_n || flags.k_eff_zero) state_in = S_DONE;
            else state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (flags.div_last) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (flags.quo_over || flags.i_last) state_in = S_DONE;
            else state_in = S_MUL;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      op        = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = OP_LOAD;
         end
         S_SETUP: begin
            op = OP_SETUP;
         end
         S_MUL: begin
            op = OP_MUL;
         end
         S_DIV: begin
            op = OP_DIV;
         end
         S_CHECK: begin
            op = OP_CHECK;
         end
         S_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/binomial_coefficient.sv
// Binomial coefficient unit: C(n,k) by the exact multiplicative formula.
//
// Request channel req_ch carries n_total and k_chosen; response channel rsp_ch
// carries coefficient and status (ok, k exceeds n, overflow). Both are
// valid/ready; a transaction moves on a clock edge with valid and ready high.
// One request is worked at a time. k is reflected to n-k when it exceeds n/2,
// then rounds run, each a multiply of the accumulator by n-k+i and an exact
// radix-2 restoring division by i, one quotient bit per cycle in a shared
// divider. The number of rounds run is r: k' (the reflected k), or fewer when
// the quotient passes RESULT_BITS bits and the rounds end early with overflow.
// No rounds run when k is zero, equal to n, or above n; at the default widths
// r never exceeds 34. The next request is accepted at the earliest in the
// cycle after the response is loaded. The response sits in an output
// register, so a new request is taken while a finished response still
// waits; a stalled receiver only holds the sequencer at its last step until
// that register frees up.
// Synchronous reset returns the sequencer to idle and empties the response
// register; no clearing pass is needed.
`timescale 1ns / 1ps

module binomial_coefficient import bc_pkg::*; #(
   parameter int ARG_BITS    = ARG_BITS_DEF,
   parameter int RESULT_BITS = RESULT_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   bc_req_if.sink   req_ch,
   bc_rsp_if.source rsp_ch
);

   bc_flags_type         flags;
   bc_op_type            op;
   logic                 rsp_load, rsp_free;
   logic [COEF_BITS-1:0] res_coef;
   bc_status_type        res_status;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COEF_BITS-1:0] rsp_coef_ff;
   bc_status_type        rsp_status_ff;

   bc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_free  (rsp_free),
      .flags     (flags),
      .req_ready (req_ch.ready),
      .rsp_load  (rsp_load),
      .op        (op)
   );

   // Input bits above ARG_BITS are dropped
   bc_datapath #(
      .ARG_BITS    (ARG_BITS),
      .RESULT_BITS (RESULT_BITS)
   ) u_datapath (
      .clock      (clock),
      .op         (op),
      .n_in       (ARG_BITS'(req_ch.n_total)),
      .k_in       (ARG_BITS'(req_ch.k_chosen)),
      .flags      (flags),
      .res_coef   (res_coef),
      .res_status (res_status)
   );

   // Response output register
   assign rsp_free = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_coef_ff   <= res_coef;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.coefficient = rsp_coef_ff;
   assign rsp_ch.status      = rsp_status_ff;

`ifndef SYNTHESIS
   // Not ready in the cycle after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while still busy");

   // k above n gives zero
   a_k_gt_n_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_K_GT_N) |-> rsp_ch.coefficient == '0)
      else $error("k above n with nonzero coefficient");

   // Overflow saturates to all ones of RESULT_BITS
   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_OVERFLOW) |->
      rsp_ch.coefficient == COEF_BITS'({RESULT_BITS{1'b1}}))
      else $error("overflow without saturated coefficient");

   // A valid coefficient is at least one
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_OK) |-> rsp_ch.coefficient != '0)
      else $error("zero coefficient reported as ok");
`endif

endmodule

FILE: test/binomial_coefficient_test.sv
// Self-checking testbench for the binomial coefficient unit.
`timescale 1ns / 1ps

module binomial_coefficient_test;
   import bc_pkg::*;

   // Cycles with no transaction on either channel before the run is abandoned.
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_REQUESTS = 218;
   localparam int SETTLE_CYCLES = 50;

   typedef logic [ARG_W-1:0] arg_type;
   typedef logic [COEF_BITS-1:0] coef_type;

   typedef struct {
      arg_type       n_total;
      arg_type       k_chosen;
      coef_type      coefficient;
      bc_status_type status;
   } coef_result_type;

   // Predicts C(n,k) for each accepted request and checks responses in order.
   class binomial_scoreboard;
      coef_result_type pending_coefficients[$];
      int failures = 0;
      int reported = 0;

      // Exact product C(n-k+i, i) built one round at a time in a wide accumulator
      function automatic coef_result_type binomial_of(arg_type n, arg_type k);
         coef_result_type r;
         logic [79:0]     acc;
         logic [79:0]     factor;
         arg_type         k_eff;
         int              i;
         r.n_total  = n;
         r.k_chosen = k;
         if (k > n) begin
            r.coefficient = '0;
            r.status      = ST_K_GT_N;
            return r;
         end
         k_eff = (k > n / 2) ? arg_type'(n - k) : k;
         acc = 80'd1;
         r.status = ST_OK;
         for (i = 1; i <= k_eff && r.status == ST_OK; i++) begin
            factor = 80'(n - k_eff) + 80'(i);
            acc = acc * factor / 80'(i);
            // partial products never shrink, so the first one too wide decides
            if (acc[79:COEF_BITS] != '0) r.status = ST_OVERFLOW;
         end
         r.coefficient = (r.status == ST_OVERFLOW) ? '1 : acc[COEF_BITS-1:0];
         return r;
      endfunction

      function void note_request(arg_type n, arg_type k);
         pending_coefficients.push_back(binomial_of(n, k));
      endfunction

      function void note_failure(string what);
         failures++;
         if (reported < 10) begin
            reported++;
            $display("%0t ns: ERROR %s", $time, what);
         end
      endfunction

      function void check_response(coef_type coefficient, bc_status_type status);
         coef_result_type want;
         if (pending_coefficients.size() == 0) begin
            note_failure($sformatf("response %0d status %0d with no request outstanding",
                                   coefficient, status));
            return;
         end
         want = pending_coefficients.pop_front();
         if (coefficient !== want.coefficient || status !== want.status)
            note_failure($sformatf("C(%0d,%0d): expected %0d status %0d, got %0d status %0d",
                                   want.n_total, want.k_chosen, want.coefficient,
                                   want.status, coefficient, status));
      endfunction

      function int outstanding();
         return pending_coefficients.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm = 1'b0;
   bit   hold_off_request = 1'b0;
   int   idle_cycles = 0;

   binomial_scoreboard board = new();

   bc_req_if req_ch();
   bc_rsp_if rsp_ch();

   binomial_coefficient #(
      .ARG_BITS    (ARG_BITS_DEF),
      .RESULT_BITS (RESULT_BITS_DEF)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request, with random idle cycles first; called at a falling edge
   task automatic send_request(input arg_type n, input arg_type k);
      while (!calm && $urandom_range(99) < 28) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.n_total  <= n;
      req_ch.k_chosen <= k;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(n, k);
      @(negedge clock);
   endtask

   // Stop offering until every expected response has come back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
   endtask

   // Receiver: random back-pressure, or a long hold-off when requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 28);
         end
      end
   end

   // Response checking and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.coefficient, rsp_ch.status);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("binomial_coefficient_test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stimulus
   initial begin
      arg_type n;
      arg_type k;
      arg_type k_eff;
      int      sel;
      req_ch.valid    = 1'b0;
      req_ch.n_total  = '0;
      req_ch.k_chosen = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty set, k above n, edges, reflection and the 64-bit boundary
      send_request(7'd0, 7'd0);
      send_request(7'd0, 7'd127);
      send_request(7'd126, 7'd127);
      send_request(7'd3, 7'd5);
      send_request(7'd127, 7'd0);
      send_request(7'd127, 7'd127);
      send_request(7'd1, 7'd0);
      send_request(7'd1, 7'd1);
      send_request(7'd127, 7'd1);
      send_request(7'd127, 7'd126);
      send_request(7'd5, 7'd2);
      send_request(7'd10, 7'd7);
      send_request(7'd62, 7'd31);
      send_request(7'd64, 7'd32);
      send_request(7'd66, 7'd33);
      send_request(7'd67, 7'd33);
      send_request(7'd67, 7'd34);
      send_request(7'd68, 7'd34);
      send_request(7'd100, 7'd50);
      send_request(7'd127, 7'd10);
      send_request(7'd127, 7'd12);
      send_request(7'd127, 7'd15);
      send_request(7'd127, 7'd63);
      send_request(7'd127, 7'd64);

      // Sender pauses until every outstanding response is back
      drain_responses();
      @(negedge clock);

      // Receiver holds off while short requests keep coming, filling the unit
      hold_off_request = 1'b1;
      calm = 1'b1;
      for (int j = 0; j < 8; j++)
         send_request(arg_type'($urandom_range(127)), arg_type'($urandom_range(1) ? 0 : 1));
      calm = 1'b0;

      // Random: mostly short products, some long ones, k above n and trivial k
      for (int j = 0; j < RANDOM_REQUESTS; j++) begin
         calm = (j >= 100 && j < 140);
         sel = $urandom_range(99);
         n = arg_type'($urandom_range(127));
         if (sel < 10) begin
            n = arg_type'($urandom_range(126));
            k = arg_type'($urandom_range(127, n + 1));
         end else if (sel < 20) begin
            k = $urandom_range(1) ? n : arg_type'(0);
         end else begin
            if (sel < 70)
               k_eff = arg_type'($urandom_range(4, 1));
            else if (sel < 90)
               k_eff = arg_type'($urandom_range(16, 5));
            else
               k_eff = arg_type'($urandom_range(63, 1));
            if (k_eff > n / 2) k_eff = n / 2;
            k = $urandom_range(1) ? k_eff : arg_type'(n - k_eff);
         end
         send_request(n, k);
      end
      calm = 1'b0;

      // Wrap up once every response is in and the unit has settled
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.outstanding() != 0)
         board.note_failure($sformatf("%0d responses never arrived", board.outstanding()));
      if (board.failures == 0) begin
         $display("binomial_coefficient_test passed");
      end else begin
         $display("binomial_coefficient_test failed");
      end
      $finish;
   end

endmodule

FILE: binomial_coefficient.f
rtl/core/bc_pkg.sv
rtl/core/bc_channels.sv
rtl/core/bc_datapath.sv
rtl/core/bc_ctrl.sv
rtl/core/binomial_coefficient.sv
test/binomial_coefficient_test.sv
